// File: rtl/tis_pkg.sv
// Package for the trie insert/search block: transfer payload types and opcodes.
// Used by tis_walk_ctrl and trie_insert_search_top; depends on nothing.

package tis_pkg;

    localparam int LETTER_W = 5;
    localparam int OPCODE_W = 2;

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic overflow;
    } out_item_t;

endpackage

// File: rtl/tis_row_mem.sv
// Node-row memory: one row per trie node (word-end mark plus all child links).
// One write port, one read port, registered read data. No dependencies.

module tis_row_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 261
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data, held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tis_walk_ctrl.sv
// Walk sequencer for the trie: reads, modifies and writes node rows, allocates
// nodes and holds the result register. Depends on tis_pkg; drives tis_row_mem.

module tis_walk_ctrl #(
    parameter int NODE_COUNT = 1024,
    parameter int ALPHABET   = 26,
    parameter int IDX_W      = $clog2(NODE_COUNT),
    parameter int ROW_W      = ALPHABET * IDX_W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  tis_pkg::in_item_t s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output tis_pkg::out_item_t m_data,
    // row memory
    output logic              mem_we,
    output logic [IDX_W-1:0]  mem_waddr,
    output logic [ROW_W-1:0]  mem_wdata,
    output logic              mem_re,
    output logic [IDX_W-1:0]  mem_raddr,
    input  logic [ROW_W-1:0]  mem_rdata
);

    localparam int LTR_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic                               mark;
        logic [ALPHABET-1:0][IDX_W-1:0]     links;
    } row_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_NEWROW,
        ST_FINREAD,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic               missed_reg, missed_next;
    logic               ovf_reg, ovf_next;
    logic [1:0]         op_reg, op_next;
    logic [LTR_W-1:0]   ltr_reg, ltr_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    tis_pkg::out_item_t out_data_reg, out_data_next;

    row_t               rd_row;
    row_t               wr_row;
    logic [IDX_W-1:0]   link;
    logic               accept;
    logic               out_free;
    logic               ltr_in_range;
    logic [LTR_W-1:0]   ltr_in;

    assign rd_row       = row_t'(mem_rdata);
    assign link         = rd_row.links[ltr_reg];
    assign accept       = s_valid && s_ready;
    assign out_free     = !out_valid_reg || m_ready;
    assign ltr_in_range = 32'(s_data.letter) < ALPHABET;
    assign ltr_in       = LTR_W'(32'(s_data.letter));

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign mem_wdata = wr_row;

    // Next-state and memory control
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        missed_next    = missed_reg;
        ovf_next       = ovf_reg;
        op_next        = op_reg;
        ltr_next       = ltr_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        wr_row         = '0;
        mem_re         = 1'b0;
        mem_raddr      = cur_reg;

        // result handed off
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // zero the root row once after reset
            ST_INIT: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                state_next = ST_IDLE;
            end

            ST_IDLE: begin
                if (accept) begin
                    op_next   = s_data.opcode;
                    ltr_next  = ltr_in;
                    last_next = s_data.last_letter;
                    case (s_data.opcode)
                        tis_pkg::OP_CLEAR: begin
                            // only the root row needs zeroing; others are
                            // zeroed when allocated
                            mem_we      = 1'b1;
                            mem_waddr   = '0;
                            cur_next    = '0;
                            used_next   = CNT_W'(1);
                            missed_next = 1'b0;
                            ovf_next    = 1'b0;
                        end
                        tis_pkg::OP_INSERT, tis_pkg::OP_SEARCH: begin
                            if (missed_reg || ovf_reg) begin
                                state_next = s_data.last_letter ? ST_FINREAD : ST_IDLE;
                            end else if (!ltr_in_range) begin
                                missed_next = 1'b1;
                                state_next  = s_data.last_letter ? ST_FINREAD : ST_IDLE;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = ST_LOOKUP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // row of the current node is in the read register
            ST_LOOKUP: begin
                if (link != '0) begin
                    cur_next   = link;
                    state_next = last_reg ? ST_FINREAD : ST_IDLE;
                end else if (op_reg == tis_pkg::OP_SEARCH) begin
                    missed_next = 1'b1;
                    state_next  = last_reg ? ST_FINREAD : ST_IDLE;
                end else if (used_reg == CNT_W'(NODE_COUNT)) begin
                    ovf_next   = 1'b1;
                    state_next = last_reg ? ST_FINREAD : ST_IDLE;
                end else begin
                    // link the new node into the parent row
                    wr_row               = rd_row;
                    wr_row.links[ltr_reg] = IDX_W'(used_reg);
                    mem_we               = 1'b1;
                    cur_next             = IDX_W'(used_reg);
                    used_next            = used_reg + CNT_W'(1);
                    state_next           = ST_NEWROW;
                end
            end

            // zero the freshly allocated row
            ST_NEWROW: begin
                mem_we     = 1'b1;
                state_next = last_reg ? ST_FINREAD : ST_IDLE;
            end

            ST_FINREAD: begin
                mem_re     = 1'b1;
                state_next = ST_FINISH;
            end

            // end of key: mark or test the word end, then emit the result
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (op_reg == tis_pkg::OP_INSERT) begin
                        out_data_next.found    = 1'b0;
                        out_data_next.overflow = ovf_reg;
                        if (!ovf_reg && !missed_reg) begin
                            wr_row      = rd_row;
                            wr_row.mark = 1'b1;
                            mem_we      = 1'b1;
                        end
                    end else begin
                        out_data_next.found    = !missed_reg && !ovf_reg && rd_row.mark;
                        out_data_next.overflow = 1'b0;
                    end
                    cur_next    = '0;
                    missed_next = 1'b0;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            cur_reg       <= '0;
            used_reg      <= CNT_W'(1);
            missed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            used_reg      <= used_next;
            missed_reg    <= missed_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg       <= op_next;
        ltr_reg      <= ltr_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/trie_insert_search_top.sv
// Trie insert/search, one letter per input transfer, one result per key.
// A letter over an existing link goes through a lookup (row read); one that
// allocates a node also links it into the parent and zeroes the new row. The
// last letter then reads the final node's row before the result loads.
// Each step waits on the single row memory's read-modify-write. Reset is
// synchronous, active-low aresetn; the root row is zeroed before any transfer.

module trie_insert_search_top #(
    parameter int NODE_COUNT = 1024,
    parameter int ALPHABET   = 26
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tis_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tis_pkg::out_item_t  m_data
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int ROW_W = ALPHABET * IDX_W + 1;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [ROW_W-1:0] mem_rdata;

    // Walk sequencer and result register
    tis_walk_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .ALPHABET   (ALPHABET),
        .IDX_W      (IDX_W),
        .ROW_W      (ROW_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Node rows
    tis_row_mem #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ROW_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
